// ----- src/jcs_pkg.sv -----
// Shared types and constants for the comment stripper.
`timescale 1ns / 1ps
package jcs_pkg;

  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChSlash     = 8'h2F;
  localparam logic [7:0] ChStar      = 8'h2A;
  localparam logic [7:0] ChNewline   = 8'h0A;
  localparam logic [7:0] ChBackslash = 8'h5C;

  localparam int QDepth = 4;
  localparam int QAw    = $clog2(QDepth);

  typedef enum logic [2:0] {
    ModeNormal    = 3'd0,
    ModeSlash     = 3'd1,
    ModeStr       = 3'd2,
    ModeStrEsc    = 3'd3,
    ModeLine      = 3'd4,
    ModeBlock     = 3'd5,
    ModeBlockStar = 3'd6
  } scan_mode_e;

  typedef struct packed {
    logic       two;
    logic [7:0] first;
    logic [7:0] second;
  } entry_t;

endpackage

// ----- src/jcs_front.sv -----
// Front end: scans input words, tracks comment state, emits result entries.
`timescale 1ns / 1ps
module jcs_front import jcs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] text_byte_i,
  input  logic       end_of_text_i,
  output logic       push_o,
  output entry_t     push_entry_o,
  input  logic       push_ready_i
);

  scan_mode_e mode_q, mode_d;
  logic [1:0] cnt;
  logic [7:0] b0, b1;
  logic       accept;

  function automatic void put(input logic [7:0] ch, inout logic [1:0] n,
                              inout logic [7:0] x0, inout logic [7:0] x1);
    if (n == 2'd0) begin
      x0 = ch;
      n  = 2'd1;
    end else if (n == 2'd1) begin
      x1 = ch;
      n  = 2'd2;
    end
  endfunction

  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i && push_ready_i;

  always_comb begin
    mode_d = mode_q;
    cnt    = 2'd0;
    b0     = 8'h00;
    b1     = 8'h00;
    case (mode_q)
      ModeSlash: begin
        if (text_byte_i == ChSlash) begin
          mode_d = ModeLine;
        end else if (text_byte_i == ChStar) begin
          mode_d = ModeBlock;
        end else begin
          put(ChSlash, cnt, b0, b1);
          put(text_byte_i, cnt, b0, b1);
          mode_d = (text_byte_i == ChQuote) ? ModeStr : ModeNormal;
        end
      end
      ModeStr: begin
        put(text_byte_i, cnt, b0, b1);
        if (text_byte_i == ChQuote) begin
          mode_d = ModeNormal;
        end else if (text_byte_i == ChBackslash) begin
          mode_d = ModeStrEsc;
        end
      end
      ModeStrEsc: begin
        put(text_byte_i, cnt, b0, b1);
        mode_d = (text_byte_i == ChBackslash) ? ModeStrEsc : ModeStr;
      end
      ModeLine: begin
        if (text_byte_i == ChNewline) begin
          put(ChNewline, cnt, b0, b1);
          mode_d = ModeNormal;
        end
      end
      ModeBlock: begin
        if (text_byte_i == ChStar) begin
          mode_d = ModeBlockStar;
        end
      end
      ModeBlockStar: begin
        if (text_byte_i == ChSlash) begin
          mode_d = ModeNormal;
        end else if (text_byte_i != ChStar) begin
          mode_d = ModeBlock;
        end
      end
      default: begin
        if (text_byte_i == ChQuote) begin
          put(text_byte_i, cnt, b0, b1);
          mode_d = ModeStr;
        end else if (text_byte_i == ChSlash) begin
          mode_d = ModeSlash;
        end else begin
          put(text_byte_i, cnt, b0, b1);
          mode_d = ModeNormal;
        end
      end
    endcase
    if (end_of_text_i) begin
      if (mode_d == ModeSlash) begin
        put(ChSlash, cnt, b0, b1);
      end else if (mode_d == ModeLine) begin
        put(ChNewline, cnt, b0, b1);
      end
      mode_d = ModeNormal;
    end
  end

  assign push_o             = accept && (cnt != 2'd0);
  assign push_entry_o.two    = (cnt == 2'd2);
  assign push_entry_o.first  = b0;
  assign push_entry_o.second = b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeNormal;
    end else if (accept) begin
      mode_q <= mode_d;
    end
  end

endmodule

// ----- src/jcs_queue.sv -----
// Short FIFO of result entries between front and back.
`timescale 1ns / 1ps
module jcs_queue import jcs_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t push_entry_i,
  output logic   push_ready_o,
  input  logic   pop_i,
  output entry_t pop_entry_o,
  output logic   pop_valid_o
);

  entry_t             mem_q [QDepth];
  logic [QAw-1:0]     wr_q, rd_q;
  logic [QAw:0]       cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign push_ready_o = (cnt_q != QAw'(0) + (QAw+1)'(QDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;
  assign pop_entry_o  = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + (QAw+1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - (QAw+1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + QAw'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + QAw'(1);
      end
      cnt_q <= cnt_d;
    end
  end

endmodule

// ----- src/jcs_back.sv -----
// Back end: serializes queued entries into output words.
`timescale 1ns / 1ps
module jcs_back import jcs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       pop_valid_i,
  input  entry_t     pop_entry_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       run_end_o
);

  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       run_end_q;
  logic       pend_valid_q;
  logic [7:0] pend_byte_q;
  logic       slot_free;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign pop_o       = slot_free && !pend_valid_q && pop_valid_i;
  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign run_end_o   = run_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else if (slot_free) begin
      if (pend_valid_q) begin
        out_valid_q  <= 1'b1;
        pend_valid_q <= 1'b0;
      end else begin
        out_valid_q  <= pop_valid_i;
        pend_valid_q <= pop_valid_i && pop_entry_i.two;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_free) begin
      if (pend_valid_q) begin
        out_byte_q <= pend_byte_q;
        run_end_q  <= 1'b1;
      end else begin
        out_byte_q  <= pop_entry_i.first;
        run_end_q   <= !pop_entry_i.two;
        pend_byte_q <= pop_entry_i.second;
      end
    end
  end

endmodule

// ----- src/jsonc_comment_stripper.sv -----
// Top level: JSONC comment stripper, scanner front, entry queue, output back.
// Path: a kept byte is written into the queue, then registered in the back end's output register.
// Throughput: one input word per cycle; the back end emits one byte per cycle while
// out_ready_i is high, and sends a two-byte word (a flushed held slash) as two bytes.
// Input stalls only when the four-entry queue is full.
// Reset: asynchronous, active low; returns to normal text mode with queue empty.
`timescale 1ns / 1ps
module jsonc_comment_stripper import jcs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] text_byte_i,
  input  logic       end_of_text_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       run_end_o
);

  logic   push, push_ready, pop, pop_valid;
  entry_t push_entry, pop_entry;

  jcs_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .text_byte_i   (text_byte_i),
    .end_of_text_i (end_of_text_i),
    .push_o        (push),
    .push_entry_o  (push_entry),
    .push_ready_i  (push_ready)
  );

  jcs_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .push_ready_o (push_ready),
    .pop_i        (pop),
    .pop_entry_o  (pop_entry),
    .pop_valid_o  (pop_valid)
  );

  jcs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_entry_i (pop_entry),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .run_end_o   (run_end_o)
  );

endmodule
